// ===== hdl/dswr_pkg.sv =====
`default_nettype none

package dswr_pkg;

    localparam int FRAME_BITS          = 40;
    localparam int BIT_COUNT_W         = 6;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_W               = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int IN_TDATA_W          = 8;
    localparam int OUT_TDATA_W         = 24;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_RELEASE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TIMEOUT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD = 2'd3;

    localparam logic [CFG_W-1:0] START_LOW_RESET     = 16'd18000;
    localparam logic [CFG_W-1:0] START_RELEASE_RESET = 16'd40;
    localparam logic [CFG_W-1:0] WAIT_TIMEOUT_RESET  = 16'd10000;
    localparam logic [CFG_W-1:0] ONE_THRESHOLD_RESET = 16'd50;

    // Measurement status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] start_low_ticks;
        logic [CFG_W-1:0] start_release_ticks;
        logic [CFG_W-1:0] wait_timeout_ticks;
        logic [CFG_W-1:0] one_threshold_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] temperature;
        logic [7:0] humidity;
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       drive_high;
        logic       drive_low;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/dswr_cfg.sv =====
`default_nettype none

module dswr_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [dswr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dswr_pkg::CFG_W-1:0]       cfg_data,
    output dswr_pkg::cfg_t                        cfg
);
    import dswr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks     <= START_LOW_RESET;
            cfg_reg.start_release_ticks <= START_RELEASE_RESET;
            cfg_reg.wait_timeout_ticks  <= WAIT_TIMEOUT_RESET;
            cfg_reg.one_threshold_ticks <= ONE_THRESHOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_LOW:     cfg_reg.start_low_ticks     <= cfg_data;
                REG_START_RELEASE: cfg_reg.start_release_ticks <= cfg_data;
                REG_WAIT_TIMEOUT:  cfg_reg.wait_timeout_ticks  <= cfg_data;
                REG_ONE_THRESHOLD: cfg_reg.one_threshold_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/dswr_fsm.sv =====
`default_nettype none

module dswr_fsm #(
    parameter int COUNT_WIDTH = dswr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  dswr_pkg::cfg_t   cfg,
    input  wire logic        advance,
    input  wire logic        start_req,
    input  wire logic        line_level,
    output dswr_pkg::result_t result
);
    import dswr_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_REQ_LOW  = 3'd1;
    localparam logic [2:0] PH_RELEASE  = 3'd2;
    localparam logic [2:0] PH_ACK_LOW  = 3'd3;
    localparam logic [2:0] PH_ACK_HIGH = 3'd4;
    localparam logic [2:0] PH_GAP      = 3'd5;
    localparam logic [2:0] PH_PULSE    = 3'd6;

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] phase_ticks_reg, phase_ticks_next;
    logic [COUNT_WIDTH-1:0] pulse_ticks_reg, pulse_ticks_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]  shift_bits_reg, shift_bits_next;
    logic [7:0]             humidity_reg, humidity_next;
    logic [7:0]             temperature_reg, temperature_next;
    logic [1:0]             status_reg, status_next;

    logic [2:0]             ph;
    logic [COUNT_WIDTH-1:0] pt;
    logic [COUNT_WIDTH-1:0] pu;
    logic [BIT_COUNT_W-1:0] bc;
    logic [FRAME_BITS-1:0]  sb;
    logic                   finish;
    logic [1:0]             fin_status;
    logic                   dlow;
    logic                   dhigh;
    logic                   one_bit;
    logic [7:0]             b0, b2, b4;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // A saturated counter counts as having reached any limit.
    function automatic logic limit_hit(input logic [COUNT_WIDTH-1:0] t,
                                       input logic [CFG_W-1:0] lim);
        return (CMP_W'(t) >= CMP_W'(lim)) || (t == '1);
    endfunction

    always_comb begin
        ph = phase_reg;
        pt = phase_ticks_reg;
        pu = pulse_ticks_reg;
        bc = bit_count_reg;
        sb = shift_bits_reg;
        if (phase_reg == PH_IDLE && start_req) begin
            ph = PH_REQ_LOW;
            pt = '0;
            pu = '0;
            bc = '0;
            sb = '0;
        end

        phase_next       = ph;
        phase_ticks_next = pt;
        pulse_ticks_next = pu;
        bit_count_next   = bc;
        shift_bits_next  = sb;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        finish           = 1'b0;
        fin_status       = STATUS_OK;
        dlow             = 1'b0;
        dhigh            = 1'b0;
        one_bit          = 1'b0;
        b0               = '0;
        b2               = '0;
        b4               = '0;

        unique case (ph) inside
            PH_REQ_LOW: begin
                dlow             = 1'b1;
                phase_ticks_next = sat_inc(pt);
                if (limit_hit(phase_ticks_next, cfg.start_low_ticks)) begin
                    phase_next       = PH_RELEASE;
                    phase_ticks_next = '0;
                end
            end
            PH_RELEASE: begin
                dhigh            = 1'b1;
                phase_ticks_next = sat_inc(pt);
                if (limit_hit(phase_ticks_next, cfg.start_release_ticks)) begin
                    phase_next       = PH_ACK_LOW;
                    phase_ticks_next = '0;
                end
            end
            PH_ACK_LOW, PH_GAP: begin
                if (!line_level) begin
                    if (limit_hit(pt, cfg.wait_timeout_ticks)) begin
                        finish     = 1'b1;
                        fin_status = STATUS_TIMEOUT;
                    end else begin
                        phase_ticks_next = sat_inc(pt);
                    end
                end else if (ph == PH_ACK_LOW) begin
                    phase_next       = PH_ACK_HIGH;
                    phase_ticks_next = '0;
                end else begin
                    // The rising tick is the first tick of the pulse.
                    phase_next       = PH_PULSE;
                    phase_ticks_next = '0;
                    pulse_ticks_next = COUNT_WIDTH'(1);
                end
            end
            PH_ACK_HIGH: begin
                if (line_level) begin
                    if (limit_hit(pt, cfg.wait_timeout_ticks)) begin
                        finish     = 1'b1;
                        fin_status = STATUS_TIMEOUT;
                    end else begin
                        phase_ticks_next = sat_inc(pt);
                    end
                end else begin
                    phase_next       = PH_GAP;
                    phase_ticks_next = '0;
                end
            end
            PH_PULSE: begin
                if (line_level) begin
                    if (limit_hit(pt, cfg.wait_timeout_ticks)) begin
                        finish     = 1'b1;
                        fin_status = STATUS_TIMEOUT;
                    end else begin
                        phase_ticks_next = sat_inc(pt);
                        pulse_ticks_next = sat_inc(pu);
                    end
                end else begin
                    one_bit          = CMP_W'(pu) >= CMP_W'(cfg.one_threshold_ticks);
                    shift_bits_next  = {sb[FRAME_BITS-2:0], one_bit};
                    bit_count_next   = bc + BIT_COUNT_W'(1);
                    phase_ticks_next = '0;
                    if (bit_count_next >= BIT_COUNT_W'(FRAME_BITS)) begin
                        b0               = shift_bits_next[39:32];
                        b2               = shift_bits_next[23:16];
                        b4               = shift_bits_next[7:0];
                        humidity_next    = b0;
                        temperature_next = b2;
                        finish           = 1'b1;
                        fin_status       = ((b0 + b2) == b4) ? STATUS_OK : STATUS_CHECKSUM;
                    end else begin
                        phase_next = PH_GAP;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        status_next = status_reg;
        if (finish) begin
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
            status_next      = fin_status;
        end

        result.drive_low   = dlow;
        result.drive_high  = dhigh;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = finish;
        result.status      = status_next;
        result.humidity    = humidity_next;
        result.temperature = temperature_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            pulse_ticks_reg <= '0;
            bit_count_reg   <= '0;
            shift_bits_reg  <= '0;
            humidity_reg    <= '0;
            temperature_reg <= '0;
            status_reg      <= STATUS_OK;
        end else if (advance) begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            pulse_ticks_reg <= pulse_ticks_next;
            bit_count_reg   <= bit_count_next;
            shift_bits_reg  <= shift_bits_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
            status_reg      <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dht_single_wire_receiver_core.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata: one sampled tick
// m_        out        m_tvalid/m_tready    m_tdata: one result per tick
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick per clock while m_ does not stall: a request sits in the input
// register, the protocol step is combinational, and the result lands in
// the output register. Throughput is one request per cycle without stalls.
// Reset (synchronous, aresetn low) clears phase, counters and held results
// and restores the register defaults. A stalled m_ side holds the input
// register; s_tready drops only when both stages are full and m_tready is low.
`default_nettype none

module dht_single_wire_receiver_core #(
    parameter int COUNT_WIDTH = dswr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] start_req, [1] line_level, [7:2] zero
    input  wire logic [dswr_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] drive_low, [1] drive_high, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] humidity, [21:14] temperature, [23:22] zero
    output logic [dswr_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dswr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dswr_pkg::CFG_W-1:0]       cfg_data
);
    import dswr_pkg::*;

    logic    in_valid_reg;
    logic    in_start_reg;
    logic    in_level_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dswr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dswr_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .advance    (advance),
        .start_req  (in_start_reg),
        .line_level (in_level_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_start_reg <= s_tdata[0];
            in_level_reg <= s_tdata[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.done_res && out_data_reg.busy_res))
        else $error("done and busy set together");

    a_drive_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.drive_low && out_data_reg.drive_high))
        else $error("wire driven low and high together");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.status == STATUS_OK ||
                           out_data_reg.status == STATUS_CHECKSUM ||
                           out_data_reg.status == STATUS_TIMEOUT))
        else $error("illegal status code");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("input request lost while output stalled");

endmodule

`default_nettype wire

// ===== tb/dht_scoreboard_pkg.sv =====
`default_nettype none

package dht_scoreboard_pkg;

    import dswr_pkg::*;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_HOST_LOW,
        LINK_HOST_HIGH,
        LINK_ACK_LOW,
        LINK_ACK_HIGH,
        LINK_BIT_GAP,
        LINK_BIT_PULSE
    } link_phase_e;

    localparam int MAX_REPORTS = 50;

    class dht_scoreboard;
        // register copies
        logic [CFG_W-1:0] start_low;
        logic [CFG_W-1:0] start_release;
        logic [CFG_W-1:0] wait_timeout;
        logic [CFG_W-1:0] one_threshold;

        // protocol state
        link_phase_e        phase;
        logic [15:0]        phase_ticks;
        logic [15:0]        pulse_ticks;
        logic [5:0]         bits_seen;
        logic [39:0]        frame_bits;
        logic [7:0]         humidity_hold;
        logic [7:0]         temperature_hold;
        logic [1:0]         status_hold;

        result_t            expected_results[$];
        int                 mismatches;
        int                 ticks_taken;
        int                 ok_count;
        int                 checksum_count;
        int                 timeout_count;

        function new();
            start_low        = START_LOW_RESET;
            start_release    = START_RELEASE_RESET;
            wait_timeout     = WAIT_TIMEOUT_RESET;
            one_threshold    = ONE_THRESHOLD_RESET;
            phase            = LINK_IDLE;
            phase_ticks      = '0;
            pulse_ticks      = '0;
            bits_seen        = '0;
            frame_bits       = '0;
            humidity_hold    = '0;
            temperature_hold = '0;
            status_hold      = STATUS_OK;
            mismatches       = 0;
            ticks_taken      = 0;
            ok_count         = 0;
            checksum_count   = 0;
            timeout_count    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_START_LOW:     start_low     = val;
                REG_START_RELEASE: start_release = val;
                REG_WAIT_TIMEOUT:  wait_timeout  = val;
                REG_ONE_THRESHOLD: one_threshold = val;
                default: ;
            endcase
        endfunction

        function bit busy();
            return phase != LINK_IDLE;
        endfunction

        function bit in_host_phase();
            return phase == LINK_HOST_LOW || phase == LINK_HOST_HIGH;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        // a saturated counter counts as having reached any limit
        function bit reached(logic [15:0] ticks, logic [15:0] lim);
            return ticks >= lim || ticks == 16'hFFFF;
        endfunction

        // step one accepted tick and queue the result it must produce
        function void sample_tick(bit start, bit level);
            result_t    r;
            bit         finish;
            logic [1:0] fin_status;
            bit         bit_val;
            logic [7:0] b0;
            logic [7:0] b2;
            logic [7:0] b4;

            r          = '0;
            finish     = 1'b0;
            fin_status = STATUS_OK;
            ticks_taken++;

            if (phase == LINK_IDLE && start) begin
                phase       = LINK_HOST_LOW;
                phase_ticks = '0;
                pulse_ticks = '0;
                frame_bits  = '0;
                bits_seen   = '0;
            end

            case (phase)
                LINK_HOST_LOW: begin
                    r.drive_low = 1'b1;
                    phase_ticks = bump(phase_ticks);
                    if (reached(phase_ticks, start_low)) begin
                        phase       = LINK_HOST_HIGH;
                        phase_ticks = '0;
                    end
                end
                LINK_HOST_HIGH: begin
                    r.drive_high = 1'b1;
                    phase_ticks  = bump(phase_ticks);
                    if (reached(phase_ticks, start_release)) begin
                        phase       = LINK_ACK_LOW;
                        phase_ticks = '0;
                    end
                end
                LINK_ACK_LOW, LINK_BIT_GAP: begin
                    if (!level) begin
                        if (reached(phase_ticks, wait_timeout)) begin
                            finish     = 1'b1;
                            fin_status = STATUS_TIMEOUT;
                        end else begin
                            phase_ticks = bump(phase_ticks);
                        end
                    end else if (phase == LINK_ACK_LOW) begin
                        phase       = LINK_ACK_HIGH;
                        phase_ticks = '0;
                    end else begin
                        // the rising tick is the first tick of the pulse
                        phase       = LINK_BIT_PULSE;
                        phase_ticks = '0;
                        pulse_ticks = 16'd1;
                    end
                end
                LINK_ACK_HIGH: begin
                    if (level) begin
                        if (reached(phase_ticks, wait_timeout)) begin
                            finish     = 1'b1;
                            fin_status = STATUS_TIMEOUT;
                        end else begin
                            phase_ticks = bump(phase_ticks);
                        end
                    end else begin
                        phase       = LINK_BIT_GAP;
                        phase_ticks = '0;
                    end
                end
                LINK_BIT_PULSE: begin
                    if (level) begin
                        if (reached(phase_ticks, wait_timeout)) begin
                            finish     = 1'b1;
                            fin_status = STATUS_TIMEOUT;
                        end else begin
                            phase_ticks = bump(phase_ticks);
                            pulse_ticks = bump(pulse_ticks);
                        end
                    end else begin
                        bit_val     = pulse_ticks >= one_threshold;
                        frame_bits  = {frame_bits[38:0], bit_val};
                        bits_seen   = bits_seen + 6'd1;
                        phase_ticks = '0;
                        if (bits_seen >= FRAME_BITS) begin
                            b0               = frame_bits[39:32];
                            b2               = frame_bits[23:16];
                            b4               = frame_bits[7:0];
                            humidity_hold    = b0;
                            temperature_hold = b2;
                            finish           = 1'b1;
                            fin_status       = (8'(b0 + b2) == b4) ? STATUS_OK
                                                                   : STATUS_CHECKSUM;
                        end else begin
                            phase = LINK_BIT_GAP;
                        end
                    end
                end
                default: phase = LINK_IDLE;
            endcase

            if (finish) begin
                phase       = LINK_IDLE;
                phase_ticks = '0;
                status_hold = fin_status;
                r.done_res  = 1'b1;
                case (fin_status)
                    STATUS_OK:       ok_count++;
                    STATUS_CHECKSUM: checksum_count++;
                    default:         timeout_count++;
                endcase
            end

            r.busy_res    = phase != LINK_IDLE;
            r.status      = status_hold;
            r.humidity    = humidity_hold;
            r.temperature = temperature_hold;
            expected_results.push_back(r);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            result_t want;
            result_t got;

            got = result_t'(tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0) begin
                report("unexpected result", 0, got);
                return;
            end
            want = expected_results.pop_front();
            if (want.drive_low != got.drive_low)
                report("drive_low", want.drive_low, got.drive_low);
            if (want.drive_high != got.drive_high)
                report("drive_high", want.drive_high, got.drive_high);
            if (want.busy_res != got.busy_res)
                report("busy_res", want.busy_res, got.busy_res);
            if (want.done_res != got.done_res)
                report("done_res", want.done_res, got.done_res);
            if (want.status != got.status)
                report("status", want.status, got.status);
            if (want.humidity != got.humidity)
                report("humidity", want.humidity, got.humidity);
            if (want.temperature != got.temperature)
                report("temperature", want.temperature, got.temperature);
        endfunction
    endclass

endpackage

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dswr_pkg::*;
    import dht_scoreboard_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_TICKS = 60;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_START_LOW;
    logic [CFG_W-1:0]       cfg_data  = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int settings_used  = 1;

    dht_scoreboard sb = new();

    dht_single_wire_receiver_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles at %0t", STALL_LIMIT, $time);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one tick request and hold it until accepted
    task automatic send_tick(input bit start, input bit level);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, level, start};
        do @(posedge aclk); while (!s_tready);
        sb.sample_tick(start, level);
    endtask

    task automatic send_run(input bit level, input int n);
        repeat (n) send_tick(sb.busy() ? 1'($urandom_range(1)) : 1'b0, level);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] low_t, input logic [CFG_W-1:0] rel_t,
                              input logic [CFG_W-1:0] tmo_t, input logic [CFG_W-1:0] thr_t);
        drain();
        cfg_put(REG_START_LOW, low_t);
        cfg_put(REG_START_RELEASE, rel_t);
        cfg_put(REG_WAIT_TIMEOUT, tmo_t);
        cfg_put(REG_ONE_THRESHOLD, thr_t);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // wrong-level ticks that stay safely below the timeout
    function automatic int slack();
        return (sb.wait_timeout > 3) ? 3 : int'(sb.wait_timeout);
    endfunction

    function automatic int pulse_len(input bit one);
        int thr;
        int n;

        thr = sb.one_threshold;
        if (one)
            n = $urandom_range((thr == 0) ? 1 : thr, thr + 2);
        else
            n = (thr <= 1) ? 1 : $urandom_range(1, thr - 1);
        if (n > int'(sb.wait_timeout) + 1)
            n = int'(sb.wait_timeout) + 1;
        return n;
    endfunction

    task automatic open_measurement();
        send_tick(1'b1, 1'($urandom_range(1)));
        while (sb.in_host_phase()) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // stuck: 0 or 1 holds the line, 2 gives a random line
    task automatic finish_measurement(input int stuck);
        while (sb.busy())
            send_tick(1'($urandom_range(1)), (stuck == 2) ? 1'($urandom_range(1)) : stuck[0]);
    endtask

    // full sensor answer; a cut below 40 stops after that bit's pulse
    task automatic send_frame(input logic [7:0] hum, input logic [7:0] tmp, input bit good_sum,
                              input int cut, input int stuck);
        logic [7:0]  b1;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [39:0] frame;
        int          i;

        b1    = 8'($urandom);
        b3    = 8'($urandom);
        b4    = good_sum ? 8'(hum + tmp) : 8'(hum + tmp + 8'($urandom_range(1, 255)));
        frame = {hum, b1, tmp, b3, b4};
        open_measurement();
        send_run(1'b0, $urandom_range(0, slack()));
        send_run(1'b1, 1 + $urandom_range(0, slack()));
        for (i = 0; i < FRAME_BITS; i++) begin
            send_run(1'b0, 1 + $urandom_range(0, slack()));
            send_run(1'b1, pulse_len(frame[FRAME_BITS-1-i]));
            if (i == cut) break;
        end
        if (cut < FRAME_BITS)
            finish_measurement(stuck);
        else
            send_run(1'b0, 1);
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct);
        int stop_at;
        int pick;
        bit paused;

        write_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(4, 12)), 16'($urandom_range(2, 4)));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = sb.ticks_taken + PHASE_TICKS;
        paused         = 1'b0;
        while (sb.ticks_taken < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_frame(8'($urandom), 8'($urandom), $urandom_range(3) != 0, FRAME_BITS, 0);
            end else if (pick < 80) begin
                send_frame(8'($urandom), 8'($urandom), 1'b1,
                           $urandom_range(0, FRAME_BITS - 1), $urandom_range(2));
            end else if (pick < 90) begin
                repeat (20) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                finish_measurement(2);
            end else begin
                repeat ($urandom_range(1, 5)) send_tick(1'b0, 1'($urandom_range(1)));
            end
            // hold off the sender until the pipe has emptied once per phase
            if (!paused) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle line, both levels, no start
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // short start phases, checksum that wraps
        write_regs(16'd3, 16'd2, 16'd6, 16'd3);
        send_frame(8'hFF, 8'h01, 1'b1, FRAME_BITS, 0);

        // shortest settings: every pulse reads as one, then each wait times out
        write_regs(16'd1, 16'd1, 16'd1, 16'd1);
        send_frame(8'h00, 8'h00, 1'b0, FRAME_BITS, 0);
        open_measurement();
        finish_measurement(0);
        open_measurement();
        send_run(1'b1, 1);
        finish_measurement(1);
        send_frame(8'h5A, 8'hA5, 1'b1, 3, 0);
        send_frame(8'h5A, 8'hA5, 1'b1, 20, 1);

        // zero registers: one tick per start phase, no tolerance on waits
        write_regs(16'd0, 16'd0, 16'd0, 16'd0);
        send_frame(8'h12, 8'h34, 1'b1, FRAME_BITS, 0);
        open_measurement();
        finish_measurement(1);

        random_phase(0, 0);
        random_phase(80, 0);
        random_phase(0, 80);
        random_phase(16, 16);

        drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d ticks under %0d register settings and four idle/stall mixes",
                 sb.ticks_taken, settings_used);
        $display("Measurements ended: %0d ok, %0d checksum errors, %0d timeouts",
                 sb.ok_count, sb.checksum_count, sb.timeout_count);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
